// ===== rtl/core/dpwh_pkg.sv =====
package dpwh_pkg;

  // Widths of the configuration and sample fields.
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned BEAM_W = 3;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned MAX_SENSORS = 4;

  localparam logic [VAL_W-1:0] COUNT_MAX = {VAL_W{1'b1}};

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PULSE_MIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_PULSE_MAX      = 3'd1;
  localparam logic [IDX_W-1:0] REG_RANGE_LOW      = 3'd2;
  localparam logic [IDX_W-1:0] REG_RANGE_HIGH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_HOLDOFF_MS     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CROSS_INHIBIT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_IR_ENABLE      = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [VAL_W-1:0] RST_PULSE_MIN     = 16'd2;
  localparam logic [VAL_W-1:0] RST_PULSE_MAX     = 16'd20;
  localparam logic [VAL_W-1:0] RST_RANGE_LOW     = 16'd400;
  localparam logic [VAL_W-1:0] RST_RANGE_HIGH    = 16'd1500;
  localparam logic [VAL_W-1:0] RST_HOLDOFF_MS    = 16'd1500;
  localparam logic [VAL_W-1:0] RST_CROSS_INHIBIT = 16'd100;

  // Distance window seen by each sensor lane.
  typedef struct packed {
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] high;
  } range_win_t;

  // Settings used by the detection core.
  typedef struct packed {
    logic [VAL_W-1:0] pulse_min;
    logic [VAL_W-1:0] pulse_max;
    logic [VAL_W-1:0] holdoff_ms;
    logic [VAL_W-1:0] cross_inhibit_ms;
    logic             ir_enable;
  } det_cfg_t;

  // One result.
  typedef struct packed {
    logic ultra_hit;
    logic ir_hit;
  } hit_t;

endpackage

// ===== rtl/core/dual_pulse_width_hit_detector_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  now_ms, distance_0..3, beam_lines
// out      output     out_valid/out_stall  ultra_hit, ir_hit
// config   input      write_enable         write_index, write_data
//
// One request is taken per cycle while in_stall is low; its result is registered in the result buffer.
// Per-sensor range lanes and both detection paths are combinational.
// A two-entry result buffer keeps requests flowing while out_stall is high;
// in_stall rises only when both entries wait.
// Reset is synchronous: counters, lockout times and the buffer clear and
// the registers take their defaults.
module dual_pulse_width_hit_detector_unit #(
  parameter int unsigned SENSOR_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [dpwh_pkg::IDX_W-1:0]   write_index,
  input  logic [dpwh_pkg::VAL_W-1:0]   write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dpwh_pkg::TIME_W-1:0]  now_ms,
  input  logic [dpwh_pkg::VAL_W-1:0]   distance_0,
  input  logic [dpwh_pkg::VAL_W-1:0]   distance_1,
  input  logic [dpwh_pkg::VAL_W-1:0]   distance_2,
  input  logic [dpwh_pkg::VAL_W-1:0]   distance_3,
  input  logic [dpwh_pkg::BEAM_W-1:0]  beam_lines,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ultra_hit,
  output logic                         ir_hit
);

  logic [dpwh_pkg::VAL_W-1:0] pulse_min, pulse_max, range_low, range_high;
  logic [dpwh_pkg::VAL_W-1:0] holdoff_ms, cross_inhibit_ms;
  logic                       ir_enable;

  logic [dpwh_pkg::VAL_W-1:0] sensor_d [dpwh_pkg::MAX_SENSORS];
  logic [SENSOR_COUNT-1:0]    lane_in_range;
  dpwh_pkg::range_win_t       win;
  dpwh_pkg::det_cfg_t         det_cfg;
  dpwh_pkg::hit_t             det_hit, head;
  logic                       step, pop, buf_full;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min        <= dpwh_pkg::RST_PULSE_MIN;
      pulse_max        <= dpwh_pkg::RST_PULSE_MAX;
      range_low        <= dpwh_pkg::RST_RANGE_LOW;
      range_high       <= dpwh_pkg::RST_RANGE_HIGH;
      holdoff_ms       <= dpwh_pkg::RST_HOLDOFF_MS;
      cross_inhibit_ms <= dpwh_pkg::RST_CROSS_INHIBIT;
      ir_enable        <= 1'b1;
    end else if (write_enable) begin
      case (write_index)
        dpwh_pkg::REG_PULSE_MIN:     pulse_min        <= write_data;
        dpwh_pkg::REG_PULSE_MAX:     pulse_max        <= write_data;
        dpwh_pkg::REG_RANGE_LOW:     range_low        <= write_data;
        dpwh_pkg::REG_RANGE_HIGH:    range_high       <= write_data;
        dpwh_pkg::REG_HOLDOFF_MS:    holdoff_ms       <= write_data;
        dpwh_pkg::REG_CROSS_INHIBIT: cross_inhibit_ms <= write_data;
        dpwh_pkg::REG_IR_ENABLE:     ir_enable        <= write_data[0];
        default: ;
      endcase
    end
  end

  assign win.low  = range_low;
  assign win.high = range_high;

  assign det_cfg.pulse_min        = pulse_min;
  assign det_cfg.pulse_max        = pulse_max;
  assign det_cfg.holdoff_ms       = holdoff_ms;
  assign det_cfg.cross_inhibit_ms = cross_inhibit_ms;
  assign det_cfg.ir_enable        = ir_enable;

  assign sensor_d[0] = distance_0;
  assign sensor_d[1] = distance_1;
  assign sensor_d[2] = distance_2;
  assign sensor_d[3] = distance_3;

  // One range lane per fitted sensor.
  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    dpwh_range_lane u_lane (
      .distance (sensor_d[i]),
      .win      (win),
      .in_range (lane_in_range[i])
    );
  end

  // Handshakes.
  assign in_stall = buf_full;
  assign step     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // Both detection paths; the lanes merge by a plain OR.
  dpwh_detect u_detect (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .cfg          (det_cfg),
    .now_ms       (now_ms),
    .any_in_range (|lane_in_range),
    .beam_lines   (beam_lines),
    .hit          (det_hit)
  );

  // Result buffer.
  dpwh_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (det_hit),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .full      (buf_full)
  );

  assign ultra_hit = head.ultra_hit;
  assign ir_hit    = head.ir_hit;

  // A full buffer always has a result on offer.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("request stalled with no result pending");

  // Nothing is on offer right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // A disabled IR path never fires.
  assert property (@(posedge clk) disable iff (rst) (step && !ir_enable) |-> !det_hit.ir_hit)
    else $error("IR hit while the IR path is disabled");

endmodule

// ===== rtl/core/dpwh_range_lane.sv =====
module dpwh_range_lane (
  input  logic [dpwh_pkg::VAL_W-1:0] distance,
  input  dpwh_pkg::range_win_t       win,
  output logic                       in_range
);

  // A present sensor counts when it reads strictly inside the window.
  assign in_range = (distance != '0) && (distance > win.low) && (distance < win.high);

endmodule

// ===== rtl/core/dpwh_detect.sv =====
module dpwh_detect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  dpwh_pkg::det_cfg_t          cfg,
  input  logic [dpwh_pkg::TIME_W-1:0] now_ms,
  input  logic                        any_in_range,
  input  logic [dpwh_pkg::BEAM_W-1:0] beam_lines,
  output dpwh_pkg::hit_t              hit
);

  logic [dpwh_pkg::VAL_W-1:0]  ultra_count, ultra_count_next;
  logic [dpwh_pkg::VAL_W-1:0]  beam_count, beam_count_next;
  logic [dpwh_pkg::TIME_W-1:0] ultra_last_time, ultra_last_time_next;
  logic [dpwh_pkg::TIME_W-1:0] beam_last_time, beam_last_time_next;

  logic [dpwh_pkg::TIME_W-1:0] ultra_age, beam_age, holdoff_wide;
  logic                        ultra_locked, beam_locked;
  logic [dpwh_pkg::VAL_W-1:0]  ultra_bumped, beam_bumped, inhibit_off;
  logic                        ultra_in_win, beam_in_win;

  // Lockout tests on modular time differences.
  assign holdoff_wide = {{(dpwh_pkg::TIME_W-dpwh_pkg::VAL_W){1'b0}}, cfg.holdoff_ms};
  assign ultra_age    = now_ms - ultra_last_time;
  assign beam_age     = now_ms - beam_last_time;
  assign ultra_locked = ultra_age < holdoff_wide;
  assign beam_locked  = beam_age < holdoff_wide;

  // Saturating counter increments and pulse window checks.
  assign ultra_bumped = (ultra_count == dpwh_pkg::COUNT_MAX) ? ultra_count
                                                             : ultra_count + 16'd1;
  assign beam_bumped  = (beam_count == dpwh_pkg::COUNT_MAX) ? beam_count
                                                            : beam_count + 16'd1;
  assign ultra_in_win = (ultra_count > cfg.pulse_min) && (ultra_count < cfg.pulse_max);
  assign beam_in_win  = (beam_bumped > cfg.pulse_min) && (beam_bumped < cfg.pulse_max);

  // An IR hit leaves the ultrasonic path only the cross inhibit to wait out, or the full holdoff when that is shorter.
  assign inhibit_off = (cfg.holdoff_ms > cfg.cross_inhibit_ms) ?
                       cfg.holdoff_ms - cfg.cross_inhibit_ms : '0;

  // Next state of both paths; the IR path runs after the ultrasonic one.
  always_comb begin
    ultra_count_next     = ultra_count;
    ultra_last_time_next = ultra_last_time;
    beam_count_next      = beam_count;
    beam_last_time_next  = beam_last_time;
    hit                  = '0;

    if (!ultra_locked) begin
      if (any_in_range) begin
        ultra_count_next = ultra_bumped;
      end else begin
        if (ultra_in_win) begin
          ultra_last_time_next = now_ms;
          hit.ultra_hit        = 1'b1;
        end
        ultra_count_next = '0;
      end
    end

    if (cfg.ir_enable && !beam_locked) begin
      if (beam_lines != '0) begin
        beam_count_next = beam_bumped;
        if (beam_in_win) begin
          beam_last_time_next  = now_ms;
          ultra_last_time_next = now_ms -
            {{(dpwh_pkg::TIME_W-dpwh_pkg::VAL_W){1'b0}}, inhibit_off};
          hit.ir_hit           = 1'b1;
        end
      end else begin
        beam_count_next = '0;
      end
    end
  end

  // State advances once for each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      ultra_count     <= '0;
      ultra_last_time <= '0;
      beam_count      <= '0;
      beam_last_time  <= '0;
    end else if (step) begin
      ultra_count     <= ultra_count_next;
      ultra_last_time <= ultra_last_time_next;
      beam_count      <= beam_count_next;
      beam_last_time  <= beam_last_time_next;
    end
  end

endmodule

// ===== rtl/core/dpwh_out_queue.sv =====
module dpwh_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpwh_pkg::hit_t push_data,
  input  logic           pop,
  output dpwh_pkg::hit_t head,
  output logic           not_empty,
  output logic           full
);

  logic [1:0]     count, count_next;
  dpwh_pkg::hit_t slot0, slot1;

  assign count_next = count + {1'b0, push} - {1'b0, pop};
  assign head       = slot0;
  assign not_empty  = count != 2'd0;
  assign full       = count == 2'd2;

  // Occupancy of the two-entry buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The head slot takes the second slot or new data as entries move on.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule
